>>> src/gdi_pkg.sv
// Package for the Gregorian date information block.
// Holds the month tables and the weekday arithmetic constants; no dependencies.
package gdi_pkg;

    localparam int unsigned DivMul   = 5243;
    localparam int unsigned DivShift = 17;
    localparam int unsigned SumW     = 15;

    localparam logic [3:0] MonthJan = 4'd1;
    localparam logic [3:0] MonthFeb = 4'd2;
    localparam logic [3:0] MonthDec = 4'd12;

    localparam logic [2:0] DowFri = 3'd5;
    localparam logic [2:0] DowSat = 3'd6;

    // Length of a month in a common year; zero for a month out of range.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // (31 * mm) / 12 for the shifted month 1..12.
    function automatic logic [4:0] month_term(input logic [3:0] mm);
        logic [4:0] t;
        unique case (mm)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd18;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd31;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

    // Days in the months after m in a common year.
    function automatic logic [8:0] rest_of_year(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd334;
            4'd2:    r = 9'd306;
            4'd3:    r = 9'd275;
            4'd4:    r = 9'd245;
            4'd5:    r = 9'd214;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd153;
            4'd8:    r = 9'd122;
            4'd9:    r = 9'd92;
            4'd10:   r = 9'd61;
            4'd11:   r = 9'd31;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/gdi_div25.sv
// Division by 25 of a 13-bit value through a reciprocal multiplication; the 8-bit quotient fits for values below 6400.
// Uses gdi_pkg for the multiplier and shift constants.
module gdi_div25 (
    input  logic [12:0] i_num,
    output logic [7:0]  o_quot
);

    logic [25:0] w_prod;

    assign w_prod = 26'(i_num) * 26'(gdi_pkg::DivMul);
    assign o_quot = w_prod[gdi_pkg::DivShift +: 8];

endmodule

>>> src/gregorian_date_info.sv
// Gregorian date information: weekday, leap year, month length and day counts.
// Uses gdi_pkg and three gdi_div25 instances.
// Three register stages: an accepted item moves through stages 1, 2 and 3, and the
// stage 3 registers drive the outputs. Throughput is one item per cycle while results are taken; each stage moves
// whenever it is empty or the stage after it is moving, so stalls back up without loss.
// Reset is synchronous and active low, and clears the stage valid bits only.
module gregorian_date_info (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_day,
    input  logic [3:0]  i_month,
    input  logic [13:0] i_year,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_date_valid,
    output logic [2:0]  o_day_of_week,
    output logic        o_is_leap_year,
    output logic [4:0]  o_days_in_month,
    output logic        o_is_end_of_week,
    output logic        o_is_weekend,
    output logic        o_is_business_day,
    output logic [2:0]  o_days_to_week_end,
    output logic [4:0]  o_days_to_month_end,
    output logic [8:0]  o_days_to_year_end
);

    localparam int unsigned SW = gdi_pkg::SumW;

    logic r_v1, r_v2, r_v3;
    logic w_adv1, w_adv2, w_adv3;

    assign w_adv3  = !r_v3 || i_ready;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;
    assign o_valid = r_v3;

    // Stage 1: shifted year and month, and the three divisions by 25.
    logic        w_a;
    logic [14:0] w_yy;
    logic [3:0]  w_mm;
    logic [7:0]  w_q100y, w_q100yy, w_q400yy;

    assign w_a  = (i_month <= gdi_pkg::MonthFeb);
    assign w_yy = 15'(i_year) + 15'd400 - 15'(w_a);
    assign w_mm = i_month + (w_a ? 4'd12 : 4'd0) - 4'd2;

    gdi_div25 u_div_y (
        .i_num  ({1'b0, i_year[13:2]}),
        .o_quot (w_q100y)
    );

    gdi_div25 u_div_yy100 (
        .i_num  (w_yy[14:2]),
        .o_quot (w_q100yy)
    );

    gdi_div25 u_div_yy400 (
        .i_num  ({2'b00, w_yy[14:4]}),
        .o_quot (w_q400yy)
    );

    logic [4:0]  r_s1_day;
    logic [3:0]  r_s1_month;
    logic [13:0] r_s1_year;
    logic [14:0] r_s1_yy;
    logic [3:0]  r_s1_mm;
    logic [7:0]  r_s1_q100y, r_s1_q100yy, r_s1_q400yy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_valid) begin
            r_s1_day    <= i_day;
            r_s1_month  <= i_month;
            r_s1_year   <= i_year;
            r_s1_yy     <= w_yy;
            r_s1_mm     <= w_mm;
            r_s1_q100y  <= w_q100y;
            r_s1_q100yy <= w_q100yy;
            r_s1_q400yy <= w_q400yy;
        end
    end

    // Stage 2: leap year, month length, validity, day counts and the weekday sum.
    logic        w_div100, w_leap;
    logic [4:0]  w_dim;
    logic        w_date_ok;
    logic [SW-1:0] w_sum;
    logic [4:0]  w_left;
    logic [8:0]  w_to_year;

    assign w_div100 = ((14'(r_s1_q100y) * 14'd100) == r_s1_year);
    assign w_leap   = (w_div100 && (r_s1_year[3:0] == 4'd0)) ||
                      (!w_div100 && (r_s1_year[1:0] == 2'd0));
    assign w_dim    = gdi_pkg::month_len(r_s1_month) +
                      5'((r_s1_month == gdi_pkg::MonthFeb) && w_leap);
    assign w_date_ok = (w_dim != 5'd0) && (r_s1_day != 5'd0) && (r_s1_day <= w_dim);
    assign w_left   = w_dim - r_s1_day;
    assign w_to_year = 9'(w_left) + gdi_pkg::rest_of_year(r_s1_month) +
                       9'((r_s1_month == gdi_pkg::MonthJan) && w_leap);
    assign w_sum = SW'(r_s1_day) + SW'(r_s1_yy) + SW'(r_s1_yy[14:2]) +
                   SW'(r_s1_q400yy) + SW'(gdi_pkg::month_term(r_s1_mm)) -
                   SW'(r_s1_q100yy);

    logic [SW-1:0] r_s2_sum;
    logic          r_s2_ok, r_s2_leap;
    logic [4:0]    r_s2_dim, r_s2_to_month;
    logic [8:0]    r_s2_to_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_v1) begin
            r_s2_sum      <= w_sum;
            r_s2_ok       <= w_date_ok;
            r_s2_leap     <= w_leap;
            r_s2_dim      <= w_dim;
            r_s2_to_month <= w_left + 5'd1;
            r_s2_to_year  <= w_to_year;
        end
    end

    // Stage 3: modulo 7 by folding octal digits, then the weekday flags.
    logic [5:0] w_fold1;
    logic [3:0] w_fold2;
    logic [2:0] w_dow;

    assign w_fold1 = 6'(r_s2_sum[2:0]) + 6'(r_s2_sum[5:3]) + 6'(r_s2_sum[8:6]) +
                     6'(r_s2_sum[11:9]) + 6'(r_s2_sum[14:12]);
    assign w_fold2 = 4'(w_fold1[2:0]) + 4'(w_fold1[5:3]);
    assign w_dow   = (w_fold2 >= 4'd7) ? 3'(w_fold2 - 4'd7) : w_fold2[2:0];

    logic       r_ok, r_leap, r_eow, r_wkend, r_bus;
    logic [2:0] r_dow, r_to_week;
    logic [4:0] r_dim, r_to_month;
    logic [8:0] r_to_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3 && r_v2) begin
            r_ok       <= r_s2_ok;
            r_leap     <= r_s2_leap;
            r_dim      <= r_s2_dim;
            r_dow      <= r_s2_ok ? w_dow : 3'd0;
            r_eow      <= r_s2_ok && (w_dow == gdi_pkg::DowSat);
            r_wkend    <= r_s2_ok && ((w_dow == gdi_pkg::DowFri) ||
                                      (w_dow == gdi_pkg::DowSat));
            r_bus      <= r_s2_ok && (w_dow != gdi_pkg::DowFri) &&
                          (w_dow != gdi_pkg::DowSat);
            r_to_week  <= r_s2_ok ? (gdi_pkg::DowSat - w_dow) : 3'd0;
            r_to_month <= r_s2_ok ? r_s2_to_month : 5'd0;
            r_to_year  <= r_s2_ok ? r_s2_to_year : 9'd0;
        end
    end

    assign o_date_valid        = r_ok;
    assign o_day_of_week       = r_dow;
    assign o_is_leap_year      = r_leap;
    assign o_days_in_month     = r_dim;
    assign o_is_end_of_week    = r_eow;
    assign o_is_weekend        = r_wkend;
    assign o_is_business_day   = r_bus;
    assign o_days_to_week_end  = r_to_week;
    assign o_days_to_month_end = r_to_month;
    assign o_days_to_year_end  = r_to_year;

endmodule

>>> tb/tb_gregorian_date_info.sv
// Self-checking testbench for gregorian_date_info: directed and random dates through
// the valid/ready channels, each result checked against a calendar predictor.
// Depends on gdi_pkg and gregorian_date_info.
module tb_gregorian_date_info;

    typedef struct {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        after_drain;
    } t_date_item;

    typedef struct {
        logic       date_ok;
        logic [2:0] weekday;
        logic       leap;
        logic [4:0] month_days;
        logic       saturday;
        logic       weekend;
        logic       workday;
        logic [2:0] to_week_end;
        logic [4:0] to_month_end;
        logic [8:0] to_year_end;
    } t_date_facts;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [4:0]  i_day = '0;
    logic [3:0]  i_month = '0;
    logic [13:0] i_year = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_date_valid;
    logic [2:0]  o_day_of_week;
    logic        o_is_leap_year;
    logic [4:0]  o_days_in_month;
    logic        o_is_end_of_week;
    logic        o_is_weekend;
    logic        o_is_business_day;
    logic [2:0]  o_days_to_week_end;
    logic [4:0]  o_days_to_month_end;
    logic [8:0]  o_days_to_year_end;

    t_date_item  dates_to_send[$];
    t_date_facts facts_due[$];
    int unsigned mismatches = 0;
    int unsigned cycle_no = 0;
    logic        taken = 1'b0;
    logic        calm;

    gregorian_date_info u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_day              (i_day),
        .i_month            (i_month),
        .i_year             (i_year),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_date_valid       (o_date_valid),
        .o_day_of_week      (o_day_of_week),
        .o_is_leap_year     (o_is_leap_year),
        .o_days_in_month    (o_days_in_month),
        .o_is_end_of_week   (o_is_end_of_week),
        .o_is_weekend       (o_is_weekend),
        .o_is_business_day  (o_is_business_day),
        .o_days_to_week_end (o_days_to_week_end),
        .o_days_to_month_end(o_days_to_month_end),
        .o_days_to_year_end (o_days_to_year_end)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic year_is_leap(input logic [13:0] y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned month_length(input logic [3:0] m, input logic [13:0] y);
        if (m < gdi_pkg::MonthJan || m > gdi_pkg::MonthDec) begin
            return 0;
        end
        if (m == gdi_pkg::MonthFeb) begin
            return year_is_leap(y) ? 29 : 28;
        end
        if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic t_date_facts date_facts(input logic [4:0] d, input logic [3:0] m,
                                               input logic [13:0] y);
        t_date_facts f;
        int unsigned len, early, yy, mm, total, left;
        f = '{default: '0};
        len = month_length(m, y);
        f.leap = year_is_leap(y);
        f.month_days = len[4:0];
        f.date_ok = (len != 0) && (d >= 1) && (d <= len);
        if (f.date_ok) begin
            // January and February count as months 11 and 12 of the year before.
            early = (m <= gdi_pkg::MonthFeb) ? 1 : 0;
            yy = y + 400 - early;
            mm = m + 12 * early - 2;
            total = d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12;
            f.weekday = 3'(total % 7);
            f.saturday = (f.weekday == gdi_pkg::DowSat);
            f.weekend = (f.weekday == gdi_pkg::DowFri) || f.saturday;
            f.workday = !f.weekend;
            f.to_week_end = gdi_pkg::DowSat - f.weekday;
            f.to_month_end = 5'(len - d + 1);
            left = len - d;
            for (int unsigned k = m + 1; k <= gdi_pkg::MonthDec; k++) begin
                left += month_length(4'(k), y);
            end
            f.to_year_end = 9'(left);
        end
        return f;
    endfunction

    task automatic queue_date(input int unsigned d, input int unsigned m, input int unsigned y,
                              input logic drain);
        t_date_item it;
        it.day = 5'(d);
        it.month = 4'(m);
        it.year = 14'(y);
        it.after_drain = drain;
        dates_to_send.push_back(it);
    endtask

    task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    assign calm = (cycle_no >= 800) && (cycle_no < 1300);

    always @(posedge i_clk) begin
        t_date_facts f;
        cycle_no <= cycle_no + 1;
        taken = i_valid && o_ready;
        if (i_rst_n) begin
            if (taken) begin
                facts_due.push_back(date_facts(i_day, i_month, i_year));
            end
            if (o_valid && i_ready) begin
                if (facts_due.size() == 0) begin
                    $display("%0t: result with no item outstanding", $time);
                    mismatches++;
                end else begin
                    f = facts_due.pop_front();
                    check_field("date_valid", f.date_ok, o_date_valid);
                    check_field("day_of_week", f.weekday, o_day_of_week);
                    check_field("is_leap_year", f.leap, o_is_leap_year);
                    check_field("days_in_month", f.month_days, o_days_in_month);
                    check_field("is_end_of_week", f.saturday, o_is_end_of_week);
                    check_field("is_weekend", f.weekend, o_is_weekend);
                    check_field("is_business_day", f.workday, o_is_business_day);
                    check_field("days_to_week_end", f.to_week_end, o_days_to_week_end);
                    check_field("days_to_month_end", f.to_month_end, o_days_to_month_end);
                    check_field("days_to_year_end", f.to_year_end, o_days_to_year_end);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        t_date_item it;
        i_ready <= calm || ($urandom_range(0, 99) >= 33);
        if (i_rst_n && (!i_valid || taken)) begin
            if (dates_to_send.size() != 0
                    && !(dates_to_send[0].after_drain && facts_due.size() != 0)
                    && (calm || $urandom_range(0, 99) >= 33)) begin
                it = dates_to_send.pop_front();
                i_valid <= 1'b1;
                i_day <= it.day;
                i_month <= it.month;
                i_year <= it.year;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    initial begin
        int unsigned d, m, y, kind, len;
        queue_date(1, 1, 1, 1'b0);
        queue_date(31, 12, 9999, 1'b0);
        queue_date(1, 1, 2024, 1'b0);
        queue_date(29, 2, 2000, 1'b0);
        queue_date(29, 2, 1900, 1'b0);
        queue_date(28, 2, 1900, 1'b0);
        queue_date(29, 2, 2004, 1'b0);
        queue_date(29, 2, 2023, 1'b0);
        queue_date(1, 3, 2000, 1'b0);
        queue_date(31, 4, 2021, 1'b0);
        queue_date(30, 4, 2021, 1'b0);
        queue_date(0, 6, 2010, 1'b0);
        queue_date(15, 0, 2010, 1'b0);
        queue_date(15, 13, 2010, 1'b0);
        queue_date(0, 0, 0, 1'b0);
        queue_date(31, 15, 16383, 1'b0);
        queue_date(1, 1, 0, 1'b0);
        queue_date(29, 2, 0, 1'b0);
        queue_date(31, 12, 0, 1'b0);
        queue_date(31, 1, 8192, 1'b0);
        queue_date(15, 6, 4096, 1'b0);
        queue_date(6, 7, 2024, 1'b0);
        queue_date(5, 7, 2024, 1'b0);
        queue_date(31, 12, 16383, 1'b0);
        for (int i = 0; i < 1000; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                m = $urandom_range(1, 12);
                if (kind < 70) begin
                    y = $urandom_range(1, 9999);
                end else if (kind < 78) begin
                    y = $urandom_range(0, 16383);
                end else begin
                    y = 100 * $urandom_range(0, 99) + $urandom_range(0, 8);
                end
                len = month_length(4'(m), 14'(y));
                d = ($urandom_range(0, 9) == 0) ? len : $urandom_range(1, len);
            end else if (kind < 92) begin
                m = $urandom_range(1, 12);
                y = $urandom_range(0, 16383);
                len = month_length(4'(m), 14'(y));
                d = (len == 31) ? 0 : $urandom_range(len + 1, 31);
            end else begin
                d = $urandom_range(0, 31);
                m = $urandom_range(0, 15);
                y = $urandom_range(0, 16383);
            end
            queue_date(d, m, y, (i == 0) || (i == 500));
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (dates_to_send.size() != 0 || i_valid || facts_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_gregorian_date_info: PASS");
        end else begin
            $display("tb_gregorian_date_info: FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_gregorian_date_info: FAIL");
        $finish;
    end

endmodule
